FILE: sv/twbc_pkg.sv
package twbc_pkg;

  localparam int OP_W     = 3;
  localparam int LETTER_W = 5;
  localparam int WAYS_W   = 25;
  localparam int STATUS_W = 2;

  localparam logic [WAYS_W-1:0] WAYS_MOD = 25'd20071027;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR       = 3'd0,
    OP_WORD_LETTER = 3'd1,
    OP_WORD_END    = 3'd2,
    OP_BEGIN_TEXT  = 3'd3,
    OP_TEXT_LETTER = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_LONG  = 2'd2,
    STAT_NOCNT = 2'd3
  } status_t;

  // a and b are both below WAYS_MOD, so one conditional subtract suffices
  function automatic logic [WAYS_W-1:0] ways_add(input logic [WAYS_W-1:0] a,
                                                 input logic [WAYS_W-1:0] b);
    logic [WAYS_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= {1'b0, WAYS_MOD}) begin
      sum = sum - {1'b0, WAYS_MOD};
    end
    return sum[WAYS_W-1:0];
  endfunction

endpackage

FILE: sv/trie_word_break_counter_unit.sv
// Dictionary trie plus word-break counter. Word letters (opcode 1) and word
// ends (opcode 2) build the trie; clear (opcode 0) empties it; begin text
// (opcode 3) opens a text, and each text letter (opcode 4), fed from the last
// letter of the text to the first, returns the number of ways the suffix so far
// splits into dictionary words, modulo 20071027. Every accepted command gives
// exactly one result on out_ways/out_status, strobed by out_valid for one cycle;
// the receiver cannot stall it. Opcodes 2, 3 and unused codes, dropped or
// rejected letters and a text letter before any begin text are answered in
// the next cycle; a word letter first reads the existing link (ST_WCHK), and
// one that allocates a node then zeroes the new child row one entry a cycle
// (ST_ZERO); clear runs the same sweep of the root row. A text letter walks
// the trie to its matched depth (at most MAX_WORD), or goes straight to
// ST_FIN when the new letter itself is outside the alphabet: the child-link
// memory port is read once per trie step, with the terminal mark and count
// reads of a step overlapping the next step. After reset the block is busy
// while the root row is cleared.
module trie_word_break_counter_unit
  import twbc_pkg::*;
#(
  parameter int NODES    = 4096,
  parameter int ALPHABET = 26,
  parameter int MAX_WORD = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [OP_W-1:0]     in_opcode,
  input  logic [LETTER_W-1:0] in_letter,
  output logic                out_valid,
  output logic [WAYS_W-1:0]   out_ways,
  output logic [STATUS_W-1:0] out_status
);

  localparam int NW     = $clog2(NODES);
  localparam int NCW    = $clog2(NODES + 1);
  localparam int LW     = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
  localparam int CDEPTH = NODES * (2 ** LW);
  localparam int WLW    = $clog2(MAX_WORD + 1);
  localparam int LHW    = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
  localparam int CHW    = $clog2(MAX_WORD + 1);

  typedef enum logic [5:0] {
    ST_ZERO  = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_WCHK  = 6'b000100,
    ST_WALK  = 6'b001000,
    ST_DRAIN = 6'b010000,
    ST_FIN   = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [WAYS_W-1:0]   out_ways_r, out_ways_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [NCW-1:0]      node_count_r, node_count_nxt;
  logic [NW-1:0]       cursor_r, cursor_nxt;
  logic [WLW-1:0]      wlen_r, wlen_nxt;
  status_t             drop_r, drop_nxt;
  logic                text_open_r, text_open_nxt;
  logic [WLW-1:0]      suffix_r, suffix_nxt;
  logic [LHW-1:0]      lhead_r, lhead_nxt;
  logic [CHW-1:0]      chead_r, chead_nxt;
  logic [NW-1:0]       zrow_r, zrow_nxt;
  logic [LW-1:0]       zcol_r, zcol_nxt;
  logic                zemit_r, zemit_nxt;
  logic                pend_r, pend_nxt;
  logic [WLW-1:0]      step_r, step_nxt;
  logic [LHW-1:0]      lptr_r, lptr_nxt;
  logic [CHW-1:0]      cptr_r, cptr_nxt;
  logic [WAYS_W-1:0]   cnt_r, cnt_nxt;
  logic [LW-1:0]       wcol_r, wcol_nxt;

  // memory ports
  logic                c_we;
  logic [NW+LW-1:0]    c_waddr, c_raddr;
  logic [NW-1:0]       c_wdata, c_rdata;
  logic                t_we;
  logic [NW-1:0]       t_waddr, t_raddr;
  logic                t_wdata, t_rdata;
  logic                l_we;
  logic [LHW-1:0]      l_waddr, l_raddr;
  logic [LETTER_W-1:0] l_wdata, l_rdata;
  logic                k_we;
  logic [CHW-1:0]      k_waddr, k_raddr;
  logic [WAYS_W-1:0]   k_wdata, k_rdata;

  logic                in_let_ok, rd_let_ok;
  logic [LW-1:0]       in_col, rd_col;
  logic [LHW-1:0]      lhead_inc, lhead_dec, lptr_dec;
  logic [CHW-1:0]      chead_inc, cptr_dec;
  logic [WAYS_W-1:0]   cnt_acc;

  twbc_ram #(.WIDTH(NW), .DEPTH(CDEPTH)) u_child (
    .clk(clk), .wr_en(c_we), .wr_addr(c_waddr), .wr_data(c_wdata),
    .rd_addr(c_raddr), .rd_data(c_rdata)
  );

  twbc_ram #(.WIDTH(1), .DEPTH(NODES)) u_term (
    .clk(clk), .wr_en(t_we), .wr_addr(t_waddr), .wr_data(t_wdata),
    .rd_addr(t_raddr), .rd_data(t_rdata)
  );

  twbc_ram #(.WIDTH(LETTER_W), .DEPTH(MAX_WORD)) u_letters (
    .clk(clk), .wr_en(l_we), .wr_addr(l_waddr), .wr_data(l_wdata),
    .rd_addr(l_raddr), .rd_data(l_rdata)
  );

  twbc_ram #(.WIDTH(WAYS_W), .DEPTH(MAX_WORD + 1)) u_counts (
    .clk(clk), .wr_en(k_we), .wr_addr(k_waddr), .wr_data(k_wdata),
    .rd_addr(k_raddr), .rd_data(k_rdata)
  );

  assign in_let_ok = int'(in_letter) < ALPHABET;
  assign rd_let_ok = int'(l_rdata) < ALPHABET;
  assign in_col    = LW'(in_letter);
  assign rd_col    = LW'(l_rdata);

  // ring pointers
  assign lhead_inc = (lhead_r == LHW'(MAX_WORD - 1)) ? '0 : lhead_r + LHW'(1);
  assign lhead_dec = (lhead_r == '0) ? LHW'(MAX_WORD - 1) : lhead_r - LHW'(1);
  assign lptr_dec  = (lptr_r == '0) ? LHW'(MAX_WORD - 1) : lptr_r - LHW'(1);
  assign chead_inc = (chead_r == CHW'(MAX_WORD)) ? '0 : chead_r + CHW'(1);
  assign cptr_dec  = (cptr_r == '0) ? CHW'(MAX_WORD) : cptr_r - CHW'(1);

  // terminal mark and suffix count of the previous trie step land together
  assign cnt_acc = (pend_r && t_rdata) ? ways_add(cnt_r, k_rdata) : cnt_r;

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = 1'b0;
    out_ways_nxt   = out_ways_r;
    out_status_nxt = out_status_r;
    node_count_nxt = node_count_r;
    cursor_nxt     = cursor_r;
    wlen_nxt       = wlen_r;
    drop_nxt       = drop_r;
    text_open_nxt  = text_open_r;
    suffix_nxt     = suffix_r;
    lhead_nxt      = lhead_r;
    chead_nxt      = chead_r;
    zrow_nxt       = zrow_r;
    zcol_nxt       = zcol_r;
    zemit_nxt      = zemit_r;
    pend_nxt       = pend_r;
    step_nxt       = step_r;
    lptr_nxt       = lptr_r;
    cptr_nxt       = cptr_r;
    cnt_nxt        = cnt_r;
    wcol_nxt       = wcol_r;

    c_we    = 1'b0;
    c_waddr = {zrow_r, zcol_r};
    c_wdata = '0;
    c_raddr = {cursor_r, in_col};
    t_we    = 1'b0;
    t_waddr = zrow_r;
    t_wdata = 1'b0;
    t_raddr = c_rdata;
    l_we    = 1'b0;
    l_waddr = lhead_inc;
    l_wdata = in_letter;
    l_raddr = lptr_r;
    k_we    = 1'b0;
    k_waddr = chead_r;
    k_wdata = cnt_r;
    k_raddr = cptr_r;

    case (state_r)
      ST_ZERO: begin
        c_we    = 1'b1;
        c_waddr = {zrow_r, zcol_r};
        c_wdata = '0;
        t_we    = (zcol_r == '0);
        t_waddr = zrow_r;
        t_wdata = 1'b0;
        if (zcol_r == LW'(ALPHABET - 1)) begin
          state_nxt      = ST_IDLE;
          out_valid_nxt  = zemit_r;
          out_ways_nxt   = '0;
          out_status_nxt = STAT_OK;
        end else begin
          zcol_nxt = zcol_r + LW'(1);
        end
      end

      ST_IDLE: begin
        if (start) begin
          out_ways_nxt   = '0;
          out_status_nxt = STAT_OK;
          case (op_t'(in_opcode))
            OP_CLEAR: begin
              node_count_nxt = NCW'(1);
              cursor_nxt     = '0;
              wlen_nxt       = '0;
              drop_nxt       = STAT_OK;
              zrow_nxt       = '0;
              zcol_nxt       = '0;
              zemit_nxt      = 1'b1;
              state_nxt      = ST_ZERO;
            end
            OP_WORD_LETTER: begin
              if (drop_r != STAT_OK) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = drop_r;
              end else if (!in_let_ok) begin
                out_valid_nxt = 1'b1;
              end else if (wlen_r >= WLW'(MAX_WORD)) begin
                drop_nxt       = STAT_LONG;
                out_valid_nxt  = 1'b1;
                out_status_nxt = STAT_LONG;
              end else begin
                c_raddr   = {cursor_r, in_col};
                wcol_nxt  = in_col;
                state_nxt = ST_WCHK;
              end
            end
            OP_WORD_END: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = drop_r;
              if (drop_r == STAT_OK && wlen_r != '0) begin
                t_we    = 1'b1;
                t_waddr = cursor_r;
                t_wdata = 1'b1;
              end
              cursor_nxt = '0;
              wlen_nxt   = '0;
              drop_nxt   = STAT_OK;
            end
            OP_BEGIN_TEXT: begin
              out_valid_nxt = 1'b1;
              suffix_nxt    = '0;
              text_open_nxt = 1'b1;
              k_we          = 1'b1;
              k_waddr       = chead_r;
              k_wdata       = WAYS_W'(1);
            end
            OP_TEXT_LETTER: begin
              if (!text_open_r) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STAT_NOCNT;
              end else begin
                lhead_nxt = lhead_inc;
                l_we      = 1'b1;
                l_waddr   = lhead_inc;
                l_wdata   = in_letter;
                if (suffix_r < WLW'(MAX_WORD)) begin
                  suffix_nxt = suffix_r + WLW'(1);
                end
                // the next-older letter sits at the old head
                l_raddr   = lhead_r;
                lptr_nxt  = lhead_dec;
                cptr_nxt  = chead_r;
                cnt_nxt   = '0;
                pend_nxt  = 1'b0;
                step_nxt  = '0;
                c_raddr   = {NW'(0), in_col};
                state_nxt = in_let_ok ? ST_WALK : ST_FIN;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      ST_WCHK: begin
        if (c_rdata != '0) begin
          cursor_nxt     = c_rdata;
          wlen_nxt       = wlen_r + WLW'(1);
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_OK;
          state_nxt      = ST_IDLE;
        end else if (node_count_r >= NCW'(NODES)) begin
          drop_nxt       = STAT_FULL;
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_FULL;
          state_nxt      = ST_IDLE;
        end else begin
          c_we           = 1'b1;
          c_waddr        = {cursor_r, wcol_r};
          c_wdata        = NW'(node_count_r);
          cursor_nxt     = NW'(node_count_r);
          node_count_nxt = node_count_r + NCW'(1);
          wlen_nxt       = wlen_r + WLW'(1);
          zrow_nxt       = NW'(node_count_r);
          zcol_nxt       = '0;
          zemit_nxt      = 1'b1;
          state_nxt      = ST_ZERO;
        end
      end

      ST_WALK: begin
        cnt_nxt = cnt_acc;
        if (c_rdata == '0) begin
          pend_nxt  = 1'b0;
          state_nxt = ST_FIN;
        end else begin
          t_raddr  = c_rdata;
          k_raddr  = cptr_r;
          cptr_nxt = cptr_dec;
          pend_nxt = 1'b1;
          if ((step_r + WLW'(1)) < suffix_r && rd_let_ok) begin
            c_raddr  = {c_rdata, rd_col};
            l_raddr  = lptr_r;
            lptr_nxt = lptr_dec;
            step_nxt = step_r + WLW'(1);
          end else begin
            state_nxt = ST_DRAIN;
          end
        end
      end

      ST_DRAIN: begin
        cnt_nxt   = cnt_acc;
        pend_nxt  = 1'b0;
        state_nxt = ST_FIN;
      end

      ST_FIN: begin
        chead_nxt      = chead_inc;
        k_we           = 1'b1;
        k_waddr        = chead_inc;
        k_wdata        = cnt_r;
        out_valid_nxt  = 1'b1;
        out_ways_nxt   = cnt_r;
        out_status_nxt = STAT_OK;
        state_nxt      = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_ZERO;
      out_valid_r  <= 1'b0;
      node_count_r <= NCW'(1);
      cursor_r     <= '0;
      wlen_r       <= '0;
      drop_r       <= STAT_OK;
      text_open_r  <= 1'b0;
      suffix_r     <= '0;
      lhead_r      <= '0;
      chead_r      <= '0;
      zrow_r       <= '0;
      zcol_r       <= '0;
      zemit_r      <= 1'b0;
      pend_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      node_count_r <= node_count_nxt;
      cursor_r     <= cursor_nxt;
      wlen_r       <= wlen_nxt;
      drop_r       <= drop_nxt;
      text_open_r  <= text_open_nxt;
      suffix_r     <= suffix_nxt;
      lhead_r      <= lhead_nxt;
      chead_r      <= chead_nxt;
      zrow_r       <= zrow_nxt;
      zcol_r       <= zcol_nxt;
      zemit_r      <= zemit_nxt;
      pend_r       <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_ways_r   <= out_ways_nxt;
    out_status_r <= out_status_nxt;
    step_r       <= step_nxt;
    lptr_r       <= lptr_nxt;
    cptr_r       <= cptr_nxt;
    cnt_r        <= cnt_nxt;
    wcol_r       <= wcol_nxt;
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_ways   = out_ways_r;
  assign out_status = out_status_r;

`ifndef SYNTHESIS
  a_accept_answered: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("accepted transaction neither answered nor in progress");

  a_ways_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_ways < WAYS_MOD))
    else $error("split count not reduced");

  a_node_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (node_count_r >= NCW'(1)) && (node_count_r <= NCW'(NODES)))
    else $error("node count out of range");

  a_walk_in_suffix: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (step_r < suffix_r))
    else $error("trie walk ran past the suffix");
`endif

endmodule

FILE: sv/twbc_ram.sv
module twbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: bench/testbench.sv
module testbench;
  import twbc_pkg::*;

  localparam int NODES        = 4096;
  localparam int ALPHABET     = 26;
  localparam int MAX_WORD     = 128;
  localparam int RANDOM_ITEMS = 1100;
  localparam int STALL_LIMIT  = 3000;
  localparam int LATE_CYCLES  = 300;
  localparam int SHOWN_FAULTS = 10;

  localparam logic [OP_W-1:0]     OP_UNUSED_LO = 3'd5;
  localparam logic [OP_W-1:0]     OP_UNUSED_HI = 3'd7;
  localparam logic [LETTER_W-1:0] LETTER_A     = 5'd0;
  localparam logic [LETTER_W-1:0] LETTER_Z     = 5'd25;
  localparam logic [LETTER_W-1:0] LETTER_TOP   = 5'd31;

  typedef enum {PICK_A, PICK_ANY, PICK_MIXED} pick_t;

  typedef struct {
    logic [OP_W-1:0]     op;
    logic [LETTER_W-1:0] ch;
    bit                  drain;
  } cmd_t;

  typedef struct {
    bit [WAYS_W-1:0] ways;
    status_t         status;
  } split_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [OP_W-1:0]     in_opcode = '0;
  logic [LETTER_W-1:0] in_letter = '0;
  logic                out_valid;
  logic [WAYS_W-1:0]   out_ways;
  logic [STATUS_W-1:0] out_status;

  cmd_t   backlog[$];
  split_t splits_due[$];
  int     n_issued = 0;
  int     n_taken = 0;
  int     gap_left = 0;
  bit     calm = 1'b0;
  int     faults = 0;
  int     stall_cycles = 0;

  // mirror of the dictionary and text state
  int unsigned     kids [NODES*ALPHABET];
  bit              term [NODES];
  int unsigned     nodes_used = 1;
  int unsigned     cursor = 0;
  int unsigned     wlen = 0;
  status_t         drop = STAT_OK;
  bit [LETTER_W-1:0] recent [MAX_WORD];
  bit [WAYS_W-1:0] sums [MAX_WORD+1];
  int unsigned     sfx_len = 0;
  int unsigned     lhead = 0;
  int unsigned     chead = 0;
  bit              text_on = 1'b0;

  trie_word_break_counter_unit #(
    .NODES   (NODES),
    .ALPHABET(ALPHABET),
    .MAX_WORD(MAX_WORD)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_opcode (in_opcode),
    .in_letter (in_letter),
    .out_valid (out_valid),
    .out_ways  (out_ways),
    .out_status(out_status)
  );

  always #5 clk = ~clk;

  function automatic split_t dict_text_step(input logic [OP_W-1:0] op,
                                            input logic [LETTER_W-1:0] ch);
    split_t r;
    int unsigned nxt, node, acc, pos, i, j;
    bit walking;
    r.ways = '0;
    r.status = STAT_OK;
    case (op)
      OP_CLEAR: begin
        for (j = 0; j < ALPHABET; j++) kids[j] = 0;
        term[0] = 1'b0;
        nodes_used = 1;
        cursor = 0;
        wlen = 0;
        drop = STAT_OK;
      end
      OP_WORD_LETTER: begin
        if (drop != STAT_OK) begin
          r.status = drop;
        end else if (ch >= ALPHABET) begin
          r.status = STAT_OK;
        end else if (wlen >= MAX_WORD) begin
          drop = STAT_LONG;
          r.status = STAT_LONG;
        end else begin
          nxt = kids[cursor*ALPHABET + ch];
          if (nxt == 0) begin
            if (nodes_used >= NODES) begin
              drop = STAT_FULL;
              r.status = STAT_FULL;
            end else begin
              nxt = nodes_used;
              for (j = 0; j < ALPHABET; j++) kids[nxt*ALPHABET + j] = 0;
              term[nxt] = 1'b0;
              kids[cursor*ALPHABET + ch] = nxt;
              nodes_used++;
            end
          end
          if (drop == STAT_OK) begin
            cursor = nxt;
            wlen++;
          end
        end
      end
      OP_WORD_END: begin
        r.status = drop;
        if (drop == STAT_OK && wlen != 0) term[cursor] = 1'b1;
        cursor = 0;
        wlen = 0;
        drop = STAT_OK;
      end
      OP_BEGIN_TEXT: begin
        sfx_len = 0;
        sums[chead] = 1;
        text_on = 1'b1;
      end
      OP_TEXT_LETTER: begin
        if (!text_on) begin
          r.status = STAT_NOCNT;
        end else begin
          lhead = (lhead + 1) % MAX_WORD;
          recent[lhead] = ch;
          if (sfx_len < MAX_WORD) sfx_len++;
          node = 0;
          acc = 0;
          walking = 1'b1;
          // walk newest letter first; a word of length i+1 leaves the suffix i+1 back
          for (i = 0; i < sfx_len && walking; i++) begin
            pos = (lhead + MAX_WORD - i) % MAX_WORD;
            nxt = (recent[pos] < ALPHABET) ? kids[node*ALPHABET + recent[pos]] : 0;
            if (nxt == 0) begin
              walking = 1'b0;
            end else begin
              node = nxt;
              if (term[node]) begin
                acc += sums[(chead + MAX_WORD + 1 - i) % (MAX_WORD + 1)];
                if (acc >= WAYS_MOD) acc -= WAYS_MOD;
              end
            end
          end
          chead = (chead + 1) % (MAX_WORD + 1);
          sums[chead] = acc[WAYS_W-1:0];
          r.ways = acc[WAYS_W-1:0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [LETTER_W-1:0] draw_letter(input pick_t how);
    int k;
    case (how)
      PICK_A:   return LETTER_A;
      PICK_ANY: return LETTER_W'($urandom_range(0, ALPHABET-1));
      default: begin
        k = $urandom_range(0, 15);
        if (k < 12) return LETTER_W'($urandom_range(0, 2));
        if (k < 14) return LETTER_W'($urandom_range(0, ALPHABET-1));
        return LETTER_W'($urandom_range(ALPHABET, 31));
      end
    endcase
  endfunction

  task automatic push_cmd(input logic [OP_W-1:0] op, input logic [LETTER_W-1:0] ch,
                          input bit drain);
    cmd_t c;
    c.op = op;
    c.ch = ch;
    c.drain = drain;
    backlog.push_back(c);
  endtask

  task automatic push_word(input int len, input pick_t how);
    int k;
    for (k = 0; k < len; k++) push_cmd(OP_WORD_LETTER, draw_letter(how), 1'b0);
    push_cmd(OP_WORD_END, draw_letter(PICK_MIXED), 1'b0);
  endtask

  task automatic push_text(input int len, input pick_t how);
    int k;
    for (k = 0; k < len; k++) push_cmd(OP_TEXT_LETTER, draw_letter(how), 1'b0);
  endtask

  task automatic note_fault(input string msg);
    if (faults < SHOWN_FAULTS) $display("%s", msg);
    faults++;
  endtask

  // driver: one transaction in flight, then a drawn gap before the next
  always @(negedge clk) begin : drive_cmds
    cmd_t nxt_cmd;
    if (rst_n && !(start && n_taken != n_issued)) begin
      if (gap_left != 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (backlog.size() != 0 &&
                   !(backlog[0].drain && splits_due.size() != 0)) begin
        nxt_cmd = backlog.pop_front();
        in_opcode <= nxt_cmd.op;
        in_letter <= nxt_cmd.ch;
        start <= 1'b1;
        n_issued++;
        if ($urandom_range(0, 39) == 0) calm = !calm;
        gap_left = calm ? 0 : $urandom_range(0, 10);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: predict on acceptance, check each strobed result in order
  always @(posedge clk) begin : watch_results
    split_t want;
    if (rst_n) begin
      if (start && !busy) begin
        splits_due.push_back(dict_text_step(in_opcode, in_letter));
        n_taken++;
      end
      if (out_valid === 1'b1) begin
        if (splits_due.size() == 0) begin
          note_fault($sformatf("unexpected result: ways=%0d status=%0d",
                               out_ways, out_status));
        end else begin
          want = splits_due.pop_front();
          if (out_ways !== want.ways || out_status !== want.status) begin
            note_fault($sformatf("mismatch: expected ways=%0d status=%0d, got ways=%0d status=%0d",
                                 want.ways, want.status, out_ways, out_status));
          end
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((start && !busy) || out_valid === 1'b1) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles == STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int i, base, seg;
    // text before any begin, spare opcodes, empty and ignored word input
    push_cmd(OP_TEXT_LETTER, LETTER_A, 1'b0);
    push_cmd(OP_TEXT_LETTER, LETTER_TOP, 1'b0);
    for (i = OP_UNUSED_LO; i <= OP_UNUSED_HI; i++) push_cmd(OP_W'(i), LETTER_TOP, 1'b0);
    push_cmd(OP_WORD_END, LETTER_A, 1'b0);
    push_cmd(OP_WORD_LETTER, LETTER_TOP, 1'b0);
    push_word(1, PICK_A);
    push_word(2, PICK_A);
    push_cmd(OP_WORD_LETTER, LETTER_Z, 1'b0);
    push_cmd(OP_WORD_END, LETTER_Z, 1'b0);
    push_cmd(OP_BEGIN_TEXT, LETTER_TOP, 1'b0);
    push_cmd(OP_TEXT_LETTER, LETTER_A, 1'b0);
    push_cmd(OP_TEXT_LETTER, LETTER_Z, 1'b0);
    push_cmd(OP_TEXT_LETTER, LETTER_TOP, 1'b0);
    push_cmd(OP_TEXT_LETTER, LETTER_A, 1'b0);
    push_cmd(OP_TEXT_LETTER, LETTER_A, 1'b0);
    // clear keeps the text open
    push_cmd(OP_CLEAR, LETTER_TOP, 1'b0);
    push_cmd(OP_TEXT_LETTER, LETTER_A, 1'b0);
    push_cmd(OP_BEGIN_TEXT, LETTER_A, 1'b0);

    // over-long word, then a word of maximum length along the same path
    push_word(MAX_WORD + 2, PICK_A);
    push_word(MAX_WORD, PICK_A);
    push_word(1, PICK_A);
    push_word(2, PICK_A);
    push_cmd(OP_BEGIN_TEXT, LETTER_A, 1'b1);
    push_text(MAX_WORD + 72, PICK_A);

    // fill the trie until it overflows
    push_cmd(OP_CLEAR, LETTER_A, 1'b1);
    repeat (34) push_word(MAX_WORD, PICK_ANY);
    push_cmd(OP_BEGIN_TEXT, LETTER_A, 1'b0);
    push_text(30, PICK_ANY);
    push_cmd(OP_CLEAR, LETTER_A, 1'b1);

    base = backlog.size();
    while (backlog.size() - base < RANDOM_ITEMS) begin
      seg = $urandom_range(0, 9);
      if (seg == 0) begin
        push_cmd(OP_CLEAR, draw_letter(PICK_MIXED), $urandom_range(0, 3) == 0);
      end else if (seg <= 3) begin
        repeat ($urandom_range(1, 6)) push_word($urandom_range(0, 5), PICK_MIXED);
      end else if (seg <= 7) begin
        if (seg != 7) push_cmd(OP_BEGIN_TEXT, draw_letter(PICK_MIXED),
                               $urandom_range(0, 3) == 0);
        push_text(($urandom_range(0, 15) == 0) ? $urandom_range(100, 160)
                                               : $urandom_range(1, 30), PICK_MIXED);
      end else begin
        repeat ($urandom_range(1, 4))
          push_cmd(OP_W'($urandom_range(0, 7)), LETTER_W'($urandom_range(0, 31)), 1'b0);
      end
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    do @(negedge clk); while (backlog.size() != 0 || start || splits_due.size() != 0);
    repeat (LATE_CYCLES) @(negedge clk);
    if (splits_due.size() != 0)
      note_fault($sformatf("%0d results never arrived", splits_due.size()));
    if (faults == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
